FILE: rtl/bmh_pkg.sv
// shared types and constants of the binary max-heap
// sizes, status and operation codes, sequencer states, compare unit bundle
// no dependencies
package bmh_pkg;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(CAPACITY);
  localparam int unsigned COUNT_W     = ADDR_W + 1;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = ((VALUE_WIDTH + COUNT_W + 7) / 8) * 8;

  // operation selector carried on the input tuser
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [COUNT_W-1:0]            count_t;

  localparam count_t COUNT_FULL = COUNT_W'(CAPACITY);

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_EX_LAST,
    ST_DN_LOAD,
    ST_DN_CHK,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_FIN
  } state_e;

  // which pair of operands the shared comparator looks at
  typedef enum logic [1:0] {
    CMP_UP,     // parent (read data) below moving value
    CMP_CHILD,  // left child below right child (read data)
    CMP_DOWN    // moving value below larger child
  } cmp_op_e;

  typedef struct packed {
    cmp_op_e op;
    value_t  cur;
    value_t  lval;
    value_t  child;
  } cmp_req_t;

endpackage

FILE: rtl/bmh_ram.sv
// generic single write, single read memory with registered read data
// holds the heap entries; no dependencies
module bmh_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/bmh_cmp.sv
// shared signed comparator of the heap sequencer
// picks its operand pair by operation code; depends on bmh_pkg
module bmh_cmp (
  input  bmh_pkg::cmp_req_t req_i,
  input  bmh_pkg::value_t   rdata_i,
  output logic              lt_o
);

  bmh_pkg::value_t opa;
  bmh_pkg::value_t opb;

  // operand select
  always_comb begin
    unique case (req_i.op)
      bmh_pkg::CMP_UP: begin
        opa = rdata_i;
        opb = req_i.cur;
      end
      bmh_pkg::CMP_CHILD: begin
        opa = req_i.lval;
        opb = rdata_i;
      end
      bmh_pkg::CMP_DOWN: begin
        opa = req_i.cur;
        opb = req_i.child;
      end
      default: begin
        opa = req_i.cur;
        opb = req_i.child;
      end
    endcase
  end

  // strict signed less-than
  assign lt_o = (opa < opb);

endmodule

FILE: rtl/bmh_seq.sv
// sequencer of the heap: sift up and sift down one level at a time
// drives the entry memory and the shared comparator; depends on bmh_pkg
module bmh_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input beat
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_kind_i,
  input  bmh_pkg::value_t                   in_value_i,
  // result beat
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bmh_pkg::value_t                   out_value_o,
  output bmh_pkg::status_e                  out_status_o,
  output bmh_pkg::count_t                   out_count_o,
  // entry memory
  output logic                              mem_we_o,
  output bmh_pkg::addr_t                    mem_waddr_o,
  output bmh_pkg::value_t                   mem_wdata_o,
  output logic                              mem_re_o,
  output bmh_pkg::addr_t                    mem_raddr_o,
  input  bmh_pkg::value_t                   mem_rdata_i,
  // shared comparator
  output bmh_pkg::cmp_req_t                 cmp_req_o,
  input  logic                              cmp_lt_i
);

  bmh_pkg::state_e  state_q, state_d;
  bmh_pkg::addr_t   pos_q, pos_d;
  bmh_pkg::count_t  cnt_q, cnt_d;
  bmh_pkg::value_t  cur_q, cur_d;
  bmh_pkg::value_t  lval_q, lval_d;
  bmh_pkg::value_t  child_q, child_d;
  bmh_pkg::addr_t   cidx_q, cidx_d;
  bmh_pkg::value_t  pend_res_q, pend_res_d;
  bmh_pkg::status_e pend_stat_q, pend_stat_d;
  logic             out_valid_q, out_valid_d;
  bmh_pkg::value_t  res_q, res_d;
  bmh_pkg::status_e stat_q, stat_d;
  bmh_pkg::count_t  ocnt_q, ocnt_d;

  bmh_pkg::addr_t   parent;
  bmh_pkg::count_t  lc;
  bmh_pkg::count_t  rc;

  // heap index arithmetic
  assign parent = bmh_pkg::addr_t'(pos_q - bmh_pkg::addr_t'(1)) >> 1;
  assign lc     = {pos_q, 1'b1};
  assign rc     = lc + bmh_pkg::count_t'(1);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmh_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cur_q       <= cur_d;
    lval_q      <= lval_d;
    child_q     <= child_d;
    cidx_q      <= cidx_d;
    pend_res_q  <= pend_res_d;
    pend_stat_q <= pend_stat_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    ocnt_q      <= ocnt_d;
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    lval_d      = lval_q;
    child_d     = child_q;
    cidx_d      = cidx_q;
    pend_res_d  = pend_res_q;
    pend_stat_d = pend_stat_q;
    res_d       = res_q;
    stat_d      = stat_q;
    ocnt_d      = ocnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = cur_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = pos_q;
    cmp_req_o.op    = bmh_pkg::CMP_DOWN;
    cmp_req_o.cur   = cur_q;
    cmp_req_o.lval  = lval_q;
    cmp_req_o.child = child_q;

    unique case (state_q)
      bmh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pend_res_d  = '0;
          pend_stat_d = bmh_pkg::STAT_OK;
          if (in_kind_i == bmh_pkg::KIND_INSERT) begin
            if (cnt_q >= bmh_pkg::COUNT_FULL) begin
              pend_stat_d = bmh_pkg::STAT_FULL;
              state_d     = bmh_pkg::ST_FIN;
            end else begin
              cur_d   = in_value_i;
              pos_d   = cnt_q[bmh_pkg::ADDR_W-1:0];
              cnt_d   = cnt_q + bmh_pkg::count_t'(1);
              state_d = bmh_pkg::ST_UP_CHK;
            end
          end else begin
            if (cnt_q == '0) begin
              pend_stat_d = bmh_pkg::STAT_EMPTY;
              state_d     = bmh_pkg::ST_FIN;
            end else begin
              // fetch the root first
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              cnt_d       = cnt_q - bmh_pkg::count_t'(1);
              state_d     = bmh_pkg::ST_EX_LAST;
            end
          end
        end
      end

      // sift up: fetch the parent unless at the root
      bmh_pkg::ST_UP_CHK: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = bmh_pkg::ST_FIN;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = parent;
          state_d     = bmh_pkg::ST_UP_CMP;
        end
      end

      // sift up: pull the parent down while it is smaller
      bmh_pkg::ST_UP_CMP: begin
        cmp_req_o.op = bmh_pkg::CMP_UP;
        mem_we_o     = 1'b1;
        if (cmp_lt_i) begin
          mem_wdata_o = mem_rdata_i;
          pos_d       = parent;
          state_d     = bmh_pkg::ST_UP_CHK;
        end else begin
          state_d = bmh_pkg::ST_FIN;
        end
      end

      // root arrives, fetch the last entry
      bmh_pkg::ST_EX_LAST: begin
        pend_res_d  = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = cnt_q[bmh_pkg::ADDR_W-1:0];
        state_d     = bmh_pkg::ST_DN_LOAD;
      end

      bmh_pkg::ST_DN_LOAD: begin
        cur_d   = mem_rdata_i;
        pos_d   = '0;
        state_d = bmh_pkg::ST_DN_CHK;
      end

      // sift down: stop at a leaf, else fetch the left child
      bmh_pkg::ST_DN_CHK: begin
        if (lc >= cnt_q) begin
          mem_we_o = 1'b1;
          state_d  = bmh_pkg::ST_FIN;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = lc[bmh_pkg::ADDR_W-1:0];
          state_d     = bmh_pkg::ST_DN_LEFT;
        end
      end

      // left child arrives, fetch the right one if present
      bmh_pkg::ST_DN_LEFT: begin
        lval_d = mem_rdata_i;
        if (rc < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rc[bmh_pkg::ADDR_W-1:0];
          state_d     = bmh_pkg::ST_DN_RIGHT;
        end else begin
          child_d = mem_rdata_i;
          cidx_d  = lc[bmh_pkg::ADDR_W-1:0];
          state_d = bmh_pkg::ST_DN_CMP;
        end
      end

      // larger child, left wins a tie
      bmh_pkg::ST_DN_RIGHT: begin
        cmp_req_o.op = bmh_pkg::CMP_CHILD;
        if (cmp_lt_i) begin
          child_d = mem_rdata_i;
          cidx_d  = rc[bmh_pkg::ADDR_W-1:0];
        end else begin
          child_d = lval_q;
          cidx_d  = lc[bmh_pkg::ADDR_W-1:0];
        end
        state_d = bmh_pkg::ST_DN_CMP;
      end

      // move the child up while it is larger than the moving value
      bmh_pkg::ST_DN_CMP: begin
        cmp_req_o.op = bmh_pkg::CMP_DOWN;
        mem_we_o     = 1'b1;
        if (cmp_lt_i) begin
          mem_wdata_o = child_q;
          pos_d       = cidx_q;
          state_d     = bmh_pkg::ST_DN_CHK;
        end else begin
          state_d = bmh_pkg::ST_FIN;
        end
      end

      // hand the result to the output register once it is free
      bmh_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_d       = pend_res_q;
          stat_d      = pend_stat_q;
          ocnt_d      = cnt_q;
          state_d     = bmh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bmh_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = res_q;
  assign out_status_o = stat_q;
  assign out_count_o  = ocnt_q;

endmodule

FILE: rtl/binary_max_heap.sv
// binary max-heap priority queue of signed values, top level
// stream ports, sequencer, shared comparator and entry memory
// depends on bmh_pkg, bmh_seq, bmh_cmp, bmh_ram
//
// usage
//   input stream: tuser selects the operation (0 insert, 1 extract maximum),
//   tdata carries the signed value to insert (ignored on extract).
//   output stream: one beat per input beat; tdata holds the extracted value
//   (zero on insert or failure) in bits 31:0 and the entry count after the
//   operation in bits 42:32; tuser holds the status (0 ok, 1 extract from
//   empty, 2 insert into full).
//   one item at a time through one memory port and one comparator; an insert
//   fetches and compares the parent once per level climbed; an extract fetches
//   the root and the last entry, then per level sunk fetches the left child, the
//   right one if present, and compares; full and empty go straight to the result;
//   at most 10 levels. tready is low until the result beat is presented.
//   a finished result sits in an output register; the next item is taken
//   while it waits, and that item finishes once the register is free.
//   reset empties the heap; memory contents are not cleared and need no
//   clearing pass, since only entries below the count are read.
module binary_max_heap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [bmh_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,   // value[31:0]
  input  logic [0:0]                       s_axis_tuser_i,   // kind[0]
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [bmh_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,   // result_value[31:0], count[42:32], zero fill
  output logic [bmh_pkg::STATUS_W-1:0]     m_axis_tuser_o    // status[1:0]
);

  logic              mem_we;
  bmh_pkg::addr_t    mem_waddr;
  bmh_pkg::value_t   mem_wdata;
  logic              mem_re;
  bmh_pkg::addr_t    mem_raddr;
  bmh_pkg::value_t   mem_rdata;
  bmh_pkg::cmp_req_t cmp_req;
  logic              cmp_lt;
  bmh_pkg::value_t   out_value;
  bmh_pkg::status_e  out_status;
  bmh_pkg::count_t   out_count;

  // sequencer
  bmh_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_kind_i    (s_axis_tuser_i[0]),
    .in_value_i   (bmh_pkg::value_t'(s_axis_tdata_i[bmh_pkg::VALUE_WIDTH-1:0])),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (out_value),
    .out_status_o (out_status),
    .out_count_o  (out_count),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .cmp_req_o    (cmp_req),
    .cmp_lt_i     (cmp_lt)
  );

  // shared comparator
  bmh_cmp u_cmp (
    .req_i   (cmp_req),
    .rdata_i (mem_rdata),
    .lt_o    (cmp_lt)
  );

  // entry memory
  bmh_ram #(
    .DEPTH (bmh_pkg::CAPACITY),
    .WIDTH (bmh_pkg::VALUE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output packing
  assign m_axis_tdata_o = {
    (bmh_pkg::OUT_DATA_W - bmh_pkg::VALUE_WIDTH - bmh_pkg::COUNT_W)'(0),
    out_count, out_value
  };
  assign m_axis_tuser_o = out_status;

endmodule

FILE: rtl/bmh_checker.sv
// port-level assertions for the binary max-heap, bound to the top level
// depends on bmh_pkg and binary_max_heap
module bmh_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [bmh_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [0:0]                     s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bmh_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [bmh_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  // a taken item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after an accepted beat");

  // an empty status reports a count of zero
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == bmh_pkg::STAT_EMPTY
      |-> m_axis_tdata_o[bmh_pkg::VALUE_WIDTH+bmh_pkg::COUNT_W-1:bmh_pkg::VALUE_WIDTH] == '0)
    else $error("empty status with non-zero count");

  // a full status reports the capacity as count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == bmh_pkg::STAT_FULL
      |-> m_axis_tdata_o[bmh_pkg::VALUE_WIDTH+bmh_pkg::COUNT_W-1:bmh_pkg::VALUE_WIDTH]
          == bmh_pkg::COUNT_FULL)
    else $error("full status with count below capacity");

  // failed operations return zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != bmh_pkg::STAT_OK
      |-> m_axis_tdata_o[bmh_pkg::VALUE_WIDTH-1:0] == '0)
    else $error("non-zero value on a failed operation");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
      |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

endmodule

bind binary_max_heap bmh_checker u_bmh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: test/binary_max_heap_test.sv
// self-checking testbench for the binary max-heap priority queue
// drives insert and extract beats, predicts every result with its own heap copy
// depends on bmh_pkg and binary_max_heap
module binary_max_heap_test;
  import bmh_pkg::*;

  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int unsigned HOLD_AT     = 200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 64;

  typedef struct {
    logic   kind;
    value_t value;
    bit     drain_first;   // sender waits until every result is back
  } heap_op_t;

  typedef struct packed {
    value_t  value;
    status_e status;
    count_t  count;
  } heap_result_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  heap_op_t     pending_ops[$];
  heap_result_t expected_results[$];

  // predictor state
  value_t      model_heap [CAPACITY];
  int unsigned model_size = 0;
  int unsigned peak_size  = 0;
  int unsigned full_hits  = 0;
  int unsigned empty_hits = 0;
  int unsigned deep_pops  = 0;

  int unsigned cycle_count  = 0;
  int unsigned ops_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned gen_count    = 0;
  bit          timed_out    = 1'b0;

  heap_op_t     drv_item = '{KIND_INSERT, '0, 1'b0};
  bit           drv_offer;
  bit           drv_steady = 1'b0;
  int unsigned  drv_gap    = 0;
  bit           mon_steady = 1'b0;
  int unsigned  mon_gap    = 0;
  heap_result_t mon_exp;

  binary_max_heap u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),          // value[31:0]
    .s_axis_tuser_i  (s_tuser),          // kind[0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // result_value[31:0], count[42:32], zero fill
    .m_axis_tuser_o  (m_axis_tuser_o)    // status[1:0]
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // apply one operation to the predictor heap and return its result
  function automatic heap_result_t heap_apply(input logic kind, input value_t v);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  up;
    int unsigned  best;
    value_t       tmp;
    r.value  = '0;
    r.status = STAT_OK;
    if (kind == KIND_INSERT) begin
      if (model_size >= CAPACITY) begin
        r.status = STAT_FULL;
        full_hits++;
      end else begin
        pos = model_size;
        model_heap[pos] = v;
        model_size++;
        if (model_size > peak_size) peak_size = model_size;
        // climb while the parent is strictly smaller
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(model_heap[up] < model_heap[pos])) break;
          tmp = model_heap[up];
          model_heap[up] = model_heap[pos];
          model_heap[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (model_size == 0) begin
        r.status = STAT_EMPTY;
        empty_hits++;
      end else begin
        r.value = model_heap[0];
        if (model_size > CAPACITY / 2) deep_pops++;
        model_size--;
        model_heap[0] = model_heap[model_size];
        pos = 0;
        // sink towards the larger child, left wins on a tie
        forever begin
          best = pos;
          if (2 * pos + 1 < model_size && model_heap[best] < model_heap[2 * pos + 1])
            best = 2 * pos + 1;
          if (2 * pos + 2 < model_size && model_heap[best] < model_heap[2 * pos + 2])
            best = 2 * pos + 2;
          if (best == pos) break;
          tmp = model_heap[pos];
          model_heap[pos] = model_heap[best];
          model_heap[best] = tmp;
          pos = best;
        end
      end
    end
    r.count = count_t'(model_size);
    return r;
  endfunction

  // queue one operation, keeping track of the occupancy it leads to
  task automatic add_op(input logic kind, input value_t v, input bit drain_first = 1'b0);
    pending_ops.push_back('{kind, v, drain_first});
    if (kind == KIND_INSERT && gen_count < CAPACITY) gen_count++;
    else if (kind == KIND_EXTRACT && gen_count > 0) gen_count--;
  endtask

  // mix of extremes, a narrow band for ties, and full-range values
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return value_t'(32'h7fff_ffff);
      1:       return value_t'(32'h8000_0000);
      2, 3:    return value_t'($urandom_range(0, 16)) - value_t'(8);
      default: return value_t'($urandom);
    endcase
  endfunction

  // random operation, insert chosen with the given odds out of 100
  task automatic add_random(input int unsigned insert_pct, input bit drain_first = 1'b0);
    if ($urandom_range(1, 100) <= insert_pct) add_op(KIND_INSERT, pick_value(), drain_first);
    else add_op(KIND_EXTRACT, value_t'($urandom), drain_first);
  endtask

  // driver: one beat in flight, random gap after each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_offer = s_tvalid;
      if (s_tvalid && s_axis_tready_o) begin
        expected_results.push_back(heap_apply(drv_item.kind, drv_item.value));
        ops_accepted++;
        drv_offer = 1'b0;
        if ($urandom_range(0, 39) == 0) drv_steady = !drv_steady;
        drv_gap = drv_steady ? 0 : $urandom_range(0, 15);
      end
      if (!drv_offer) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain_first && expected_results.size() != 0)) begin
          drv_item  = pending_ops.pop_front();
          drv_offer = 1'b1;
        end
      end
      s_tvalid <= drv_offer;
      s_tdata  <= drv_item.value;
      s_tuser  <= drv_item.kind;
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tready && m_axis_tvalid_o) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no operation outstanding: tdata %h tuser %0d",
                 m_axis_tdata_o, m_axis_tuser_o);
          mismatches++;
        end else begin
          mon_exp = expected_results.pop_front();
          if (m_axis_tdata_o[31:0] !== mon_exp.value) begin
            $error("result_value: expected %0d, got %0d", mon_exp.value,
                   $signed(m_axis_tdata_o[31:0]));
            mismatches++;
          end
          if (m_axis_tuser_o !== mon_exp.status) begin
            $error("status: expected %0d, got %0d", mon_exp.status, m_axis_tuser_o);
            mismatches++;
          end
          if (m_axis_tdata_o[42:32] !== mon_exp.count) begin
            $error("count: expected %0d, got %0d", mon_exp.count, m_axis_tdata_o[42:32]);
            mismatches++;
          end
        end
        results_seen++;
        // one long hold-off so the block fills up and stalls its input
        if (results_seen == HOLD_AT) begin
          mon_gap = HOLD_CYCLES;
        end else begin
          if ($urandom_range(0, 39) == 0) mon_steady = !mon_steady;
          mon_gap = mon_steady ? 0 : $urandom_range(0, 15);
        end
      end else if (mon_gap != 0) begin
        mon_gap--;
      end
      m_tready <= (mon_gap == 0);
    end
  end

  initial begin
    // directed: empty heap, extremes, ties, then drain past empty
    add_op(KIND_EXTRACT, value_t'(32'h7fff_ffff));
    add_op(KIND_INSERT, value_t'(32'h7fff_ffff));
    add_op(KIND_INSERT, value_t'(32'h8000_0000));
    add_op(KIND_INSERT, value_t'(0));
    add_op(KIND_INSERT, value_t'(-1));
    add_op(KIND_INSERT, value_t'(1));
    add_op(KIND_INSERT, value_t'(32'h7fff_ffff));
    add_op(KIND_INSERT, value_t'(32'h8000_0000));
    add_op(KIND_INSERT, value_t'(5));
    add_op(KIND_INSERT, value_t'(5));
    add_op(KIND_INSERT, value_t'(5));
    repeat (11) add_op(KIND_EXTRACT, value_t'($urandom));

    // random near empty, sender paused first until all results are back
    add_random(50, 1'b1);
    repeat (19) add_random(50);

    // fill to capacity, then probe the full heap
    while (gen_count < CAPACITY) add_op(KIND_INSERT, pick_value());
    repeat (4) add_op(KIND_INSERT, pick_value());
    add_op(KIND_EXTRACT, value_t'($urandom));
    add_op(KIND_INSERT, pick_value());
    add_op(KIND_INSERT, pick_value());

    // deep sift-downs on a full heap, then mixed traffic
    add_op(KIND_EXTRACT, value_t'($urandom), 1'b1);
    repeat (14) add_op(KIND_EXTRACT, value_t'($urandom));
    repeat (10) add_random(45);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0) &&
           cycle_count < RUN_LIMIT)
      @(posedge clk_i);
    if (cycle_count >= RUN_LIMIT) begin
      timed_out = 1'b1;
      $error("run limit of %0d cycles reached with %0d results outstanding",
             RUN_LIMIT, expected_results.size());
    end else begin
      repeat (DRAIN_WAIT) @(posedge clk_i);
    end

    $display("%0d operations, %0d results checked, peak occupancy %0d of %0d",
             ops_accepted, results_seen, peak_size, CAPACITY);
    $display("%0d inserts into a full heap, %0d extracts from empty, %0d pops above half full",
             full_hits, empty_hits, deep_pops);
    if (!timed_out && mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
